// File: hdl/l4hp_pkg.sv
// Types and constants shared by the L4 header parser modules.
package l4hp_pkg;

    localparam int COUNT_W  = 17;
    localparam int OFFSET_W = 7;
    localparam int LENGTH_W = 16;

    localparam logic [3:0] VERSION_IPV4 = 4'd4;
    localparam logic [3:0] VERSION_IPV6 = 4'd6;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [COUNT_W-1:0] MIN_IPV4_LEN = COUNT_W'(20);
    localparam logic [COUNT_W-1:0] MIN_IPV6_LEN = COUNT_W'(40);
    localparam logic [5:0]         IPV6_HDR_LEN = 6'd40;
    localparam logic [5:0]         UDP_HDR_LEN  = 6'd8;
    localparam logic [LENGTH_W-1:0] MIN_TCP_LEN = LENGTH_W'(20);

    // Byte positions of captured header fields.
    localparam logic [COUNT_W-1:0] POS_V4_LEN_HI  = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_V4_LEN_LO  = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] POS_V4_FRAG_HI = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] POS_V4_FRAG_LO = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] POS_V4_PROTO   = COUNT_W'(9);
    localparam logic [6:0]         TCP_OFFSET_POS = 7'd12;
    localparam logic [COUNT_W-1:0] POS_V6_LEN_HI  = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] POS_V6_LEN_LO  = COUNT_W'(5);
    localparam logic [COUNT_W-1:0] POS_V6_PROTO   = COUNT_W'(6);
    localparam logic [COUNT_W-1:0] POS_V6_TCP_OFF = COUNT_W'(52);

    typedef enum logic [3:0] {
        REASON_OK        = 4'd0,
        REASON_FRAGMENT  = 4'd1,
        REASON_SHORT     = 4'd2,
        REASON_HDR_LONG  = 4'd3,
        REASON_UNDERFLOW = 4'd4,
        REASON_TRUNCATED = 4'd5,
        REASON_TCP_SMALL = 4'd6,
        REASON_TCP_OFF   = 4'd7,
        REASON_UDP_SMALL = 4'd8,
        REASON_VERSION   = 4'd9
    } reason_t;

    typedef enum logic [1:0] {
        IP_UNKNOWN = 2'd0,
        IP_V4      = 2'd1,
        IP_V6      = 2'd2
    } ip_kind_t;

    typedef enum logic [1:0] {
        L4_NONE = 2'd0,
        L4_TCP  = 2'd1,
        L4_UDP  = 2'd2
    } l4_kind_t;

    // Header fields seen so far plus the byte count.
    typedef struct packed {
        logic [COUNT_W-1:0]  byte_count;
        logic [3:0]          version_nibble;
        logic [3:0]          header_words;
        logic [LENGTH_W-1:0] ip_length_field;
        logic [7:0]          next_protocol;
        logic [12:0]         fragment_offset;
        logic [3:0]          tcp_offset_words;
    } hdr_state_t;

    typedef struct packed {
        logic                accept;
        reason_t             reason;
        ip_kind_t            ip_kind;
        l4_kind_t            l4_kind;
        logic [OFFSET_W-1:0] payload_offset;
        logic [LENGTH_W-1:0] payload_length;
    } verdict_t;

endpackage

// File: hdl/l4hp_capture.sv
// Byte counter and header field capture registers.
module l4hp_capture #(
    parameter int MAX_COUNT = 131071
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_valid,
    input  logic [7:0]            data_byte,
    input  logic                  last,
    output l4hp_pkg::hdr_state_t  state_next
);

    l4hp_pkg::hdr_state_t state_reg;
    logic [l4hp_pkg::COUNT_W-1:0] pos;
    logic [6:0]                   tcp_pos;

    assign pos     = state_reg.byte_count;
    assign tcp_pos = {1'b0, state_reg.header_words, 2'b00} + l4hp_pkg::TCP_OFFSET_POS;

    always_comb begin
        state_next = state_reg;
        if (pos < l4hp_pkg::COUNT_W'(MAX_COUNT)) begin
            state_next.byte_count = pos + 1'b1;
        end
        if (pos == '0) begin
            state_next.version_nibble = data_byte[7:4];
            state_next.header_words   = data_byte[3:0];
        end else if (state_reg.version_nibble == l4hp_pkg::VERSION_IPV4) begin
            if (pos == l4hp_pkg::POS_V4_LEN_HI) state_next.ip_length_field[15:8] = data_byte;
            if (pos == l4hp_pkg::POS_V4_LEN_LO) state_next.ip_length_field[7:0] = data_byte;
            if (pos == l4hp_pkg::POS_V4_FRAG_HI) state_next.fragment_offset[12:8] = data_byte[4:0];
            if (pos == l4hp_pkg::POS_V4_FRAG_LO) state_next.fragment_offset[7:0] = data_byte;
            if (pos == l4hp_pkg::POS_V4_PROTO) state_next.next_protocol = data_byte;
            if (pos == {{(l4hp_pkg::COUNT_W-7){1'b0}}, tcp_pos}) begin
                state_next.tcp_offset_words = data_byte[7:4];
            end
        end else if (state_reg.version_nibble == l4hp_pkg::VERSION_IPV6) begin
            if (pos == l4hp_pkg::POS_V6_LEN_HI) state_next.ip_length_field[15:8] = data_byte;
            if (pos == l4hp_pkg::POS_V6_LEN_LO) state_next.ip_length_field[7:0] = data_byte;
            if (pos == l4hp_pkg::POS_V6_PROTO) state_next.next_protocol = data_byte;
            if (pos == l4hp_pkg::POS_V6_TCP_OFF) state_next.tcp_offset_words = data_byte[7:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (byte_valid) begin
            // Clear after the last byte so the next packet starts fresh.
            if (last) begin
                state_reg <= '0;
            end else begin
                state_reg <= state_next;
            end
        end
    end

endmodule

// File: hdl/l4hp_judge.sv
// Verdict logic: checks captured header fields against the packet length.
module l4hp_judge (
    input  l4hp_pkg::hdr_state_t hdr,
    output l4hp_pkg::verdict_t   verdict
);

    logic [l4hp_pkg::COUNT_W-1:0]  len;
    logic [5:0]                    hdr_len;
    logic [5:0]                    l4_len;
    logic [l4hp_pkg::COUNT_W-1:0]  total;
    logic [l4hp_pkg::LENGTH_W-1:0] rem;
    logic [l4hp_pkg::LENGTH_W-1:0] pay;
    logic                          ip_ok;
    logic                          l4_ok;

    assign len = hdr.byte_count;

    always_comb begin
        verdict = '0;
        hdr_len = {hdr.header_words, 2'b00};
        l4_len  = {hdr.tcp_offset_words, 2'b00};
        total   = {1'b0, hdr.ip_length_field};
        rem     = '0;
        pay     = '0;
        ip_ok   = 1'b0;
        l4_ok   = 1'b0;

        if (hdr.version_nibble == l4hp_pkg::VERSION_IPV4) begin
            verdict.ip_kind = l4hp_pkg::IP_V4;
        end else if (hdr.version_nibble == l4hp_pkg::VERSION_IPV6) begin
            verdict.ip_kind = l4hp_pkg::IP_V6;
            hdr_len         = l4hp_pkg::IPV6_HDR_LEN;
            total           = {1'b0, hdr.ip_length_field} + l4hp_pkg::COUNT_W'(40);
        end else begin
            verdict.ip_kind = l4hp_pkg::IP_UNKNOWN;
        end

        if (len < l4hp_pkg::MIN_IPV4_LEN) begin
            verdict.reason = l4hp_pkg::REASON_SHORT;
        end else if (hdr.version_nibble == l4hp_pkg::VERSION_IPV4) begin
            if (len < l4hp_pkg::COUNT_W'(hdr_len)) begin
                verdict.reason = l4hp_pkg::REASON_HDR_LONG;
            end else if (hdr.ip_length_field < l4hp_pkg::LENGTH_W'(hdr_len)) begin
                verdict.reason = l4hp_pkg::REASON_UNDERFLOW;
            end else if (len < total) begin
                verdict.reason = l4hp_pkg::REASON_TRUNCATED;
            end else if (hdr.fragment_offset != '0) begin
                verdict.accept = 1'b1;
                verdict.reason = l4hp_pkg::REASON_FRAGMENT;
            end else begin
                ip_ok = 1'b1;
                rem   = hdr.ip_length_field - l4hp_pkg::LENGTH_W'(hdr_len);
            end
        end else if (hdr.version_nibble == l4hp_pkg::VERSION_IPV6) begin
            if (len < l4hp_pkg::MIN_IPV6_LEN) begin
                verdict.reason = l4hp_pkg::REASON_SHORT;
            end else if (len < total) begin
                verdict.reason = l4hp_pkg::REASON_TRUNCATED;
            end else begin
                ip_ok = 1'b1;
                rem   = hdr.ip_length_field;
            end
        end else begin
            verdict.reason = l4hp_pkg::REASON_VERSION;
        end

        if (ip_ok) begin
            if (hdr.next_protocol == l4hp_pkg::PROTO_TCP) begin
                verdict.l4_kind = l4hp_pkg::L4_TCP;
                if (rem < l4hp_pkg::MIN_TCP_LEN) begin
                    verdict.reason = l4hp_pkg::REASON_TCP_SMALL;
                end else if (rem < l4hp_pkg::LENGTH_W'(l4_len)) begin
                    verdict.reason = l4hp_pkg::REASON_TCP_OFF;
                end else begin
                    l4_ok = 1'b1;
                end
            end else if (hdr.next_protocol == l4hp_pkg::PROTO_UDP) begin
                verdict.l4_kind = l4hp_pkg::L4_UDP;
                l4_len          = l4hp_pkg::UDP_HDR_LEN;
                if (rem < l4hp_pkg::LENGTH_W'(l4hp_pkg::UDP_HDR_LEN)) begin
                    verdict.reason = l4hp_pkg::REASON_UDP_SMALL;
                end else begin
                    l4_ok = 1'b1;
                end
            end else begin
                // Other protocols pass with no payload span.
                verdict.accept = 1'b1;
            end
        end

        if (l4_ok) begin
            verdict.accept = 1'b1;
            pay = rem - l4hp_pkg::LENGTH_W'(l4_len);
            if (pay != '0) begin
                verdict.payload_offset = l4hp_pkg::OFFSET_W'(hdr_len) +
                                         l4hp_pkg::OFFSET_W'(l4_len);
                verdict.payload_length = pay;
            end
        end
    end

endmodule

// File: hdl/ip_l4_header_parser.sv
// Top level of the IPv4/IPv6 TCP/UDP header parser.
//
//  channel | direction | ports                                   | one item is
//  s_      | in        | s_valid s_ready s_data_byte s_last      | one packet byte
//  m_      | out       | m_valid m_ready m_accept m_reason ...   | one packet verdict
//
// One byte per cycle unless a stalled verdict holds back a last byte. Field
// capture and the verdict are computed in the cycle a byte is taken; the verdict
// lands in the result register in the cycle after the last byte. Reset is
// synchronous and clears the counter, fields and the result valid. A stalled
// verdict blocks only the next last byte; other bytes keep flowing.
module ip_l4_header_parser #(
    parameter int MAX_COUNT = 131071
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_accept,
    output logic [3:0]                      m_reason,
    output logic [1:0]                      m_ip_kind,
    output logic [1:0]                      m_l4_kind,
    output logic [l4hp_pkg::OFFSET_W-1:0]   m_payload_offset,
    output logic [l4hp_pkg::LENGTH_W-1:0]   m_payload_length
);

    l4hp_pkg::hdr_state_t state_next;
    l4hp_pkg::verdict_t   verdict;
    l4hp_pkg::verdict_t   result_reg;
    logic                 m_valid_reg;
    logic                 s_take;

    assign s_ready = m_ready || !m_valid_reg || !s_last;
    assign s_take  = s_valid && s_ready;

    l4hp_capture #(
        .MAX_COUNT (MAX_COUNT)
    ) u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_take),
        .data_byte  (s_data_byte),
        .last       (s_last),
        .state_next (state_next)
    );

    l4hp_judge u_judge (
        .hdr     (state_next),
        .verdict (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_take && s_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the verdict on the last byte; hold it while stalled.
    always_ff @(posedge aclk) begin
        if (s_take && s_last) begin
            result_reg <= verdict;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_accept         = result_reg.accept;
    assign m_reason         = result_reg.reason;
    assign m_ip_kind        = result_reg.ip_kind;
    assign m_l4_kind        = result_reg.l4_kind;
    assign m_payload_offset = result_reg.payload_offset;
    assign m_payload_length = result_reg.payload_length;

endmodule
